/* rtl/dq_pkg.sv */
// shared types and codes for the double-ended queue
package dq_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned ReqW    = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 5;

  // request codes
  typedef enum logic [ReqW-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_CLEAR      = 3'd4
  } req_e;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // row-wide command broadcast to every cell
  typedef struct packed {
    logic clear;
    logic shift_in_front;
    logic shift_out_front;
    logic push_back;
    logic pop_back;
  } dq_cell_ctrl_t;

  // what one cell shows its neighbors
  typedef struct packed {
    logic             valid;
    logic [WordW-1:0] word;
  } dq_link_t;

endpackage

/* rtl/dq_if.sv */
// request and response channel interfaces
interface dq_req_if import dq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic        [ReqW-1:0]    req_type;
  logic signed [WordW-1:0]   value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface dq_rsp_if import dq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [WordW-1:0]   popped;
  logic        [StatusW-1:0] status;
  logic        [CountW-1:0]  count;
  logic signed [WordW-1:0]   front_word;
  logic signed [WordW-1:0]   back_word;
  logic                      is_empty;

  modport source (output valid, output popped, output status, output count,
                  output front_word, output back_word, output is_empty, input ready);
  modport sink   (input valid, input popped, input status, input count,
                  input front_word, input back_word, input is_empty, output ready);
endinterface

/* rtl/dq_cell.sv */
// one storage cell of the queue row, position i from the front
module dq_cell import dq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dq_cell_ctrl_t    ctrl_i,
  input  logic [WordW-1:0] push_word_i,
  input  dq_link_t         left_i,
  input  dq_link_t         right_i,
  output dq_link_t         cell_o
);

  logic             valid_d, valid_q;
  logic [WordW-1:0] word_d, word_q;

  // next contents from the broadcast command and the neighbors
  always_comb begin
    valid_d = valid_q;
    word_d  = word_q;
    priority if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctrl_i.shift_in_front) begin
      valid_d = left_i.valid;
      word_d  = left_i.word;
    end else if (ctrl_i.shift_out_front) begin
      valid_d = right_i.valid;
      word_d  = right_i.word;
    end else if (ctrl_i.push_back && !valid_q && left_i.valid) begin
      valid_d = 1'b1;
      word_d  = push_word_i;
    end else if (ctrl_i.pop_back && valid_q && !right_i.valid) begin
      valid_d = 1'b0;
    end
  end

  // occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // stored word
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign cell_o.valid = valid_q;
  assign cell_o.word  = word_q;

endmodule

/* rtl/double_ended_queue_top.sv */
// double-ended queue top level: row of cells plus request control
//
//   channel  dir  handshake       payload
//   req_i    in   valid / ready   req_type, value
//   rsp_o    out  valid / ready   popped, status, count, front_word, back_word, is_empty
//
// in each transaction the cell row updates at acceptance, the result register is
// loaded from the row on the next edge, ready is low in between
// a new request is taken at the earliest in the cycle the previous result leaves
// reset clears the cell occupancy flags, the count and both channel states
// a stalled response holds req_i ready low only while the result register is full
module double_ended_queue_top import dq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  dq_req_if.sink   req_i,
  dq_rsp_if.source rsp_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  dq_link_t      cell_q   [DEPTH];
  dq_link_t      left_in  [DEPTH];
  dq_link_t      right_in [DEPTH];
  dq_cell_ctrl_t ctrl;

  logic [CntW-1:0]  cnt_d, cnt_q;
  logic             pend_q;
  logic [WordW-1:0] pop_d, pop_q;
  status_e          st_d, st_q;
  logic             accept;
  logic             full, empty;
  logic [WordW-1:0] tail_word;
  logic [CntW+CountW-1:0] cnt_ext;

  logic             out_valid_q;
  logic [WordW-1:0] out_pop_q, out_front_q, out_back_q;
  status_e          out_st_q;
  logic [CountW-1:0] out_cnt_q;
  logic             out_empty_q;

  assign accept      = req_i.valid && req_i.ready;
  assign req_i.ready = !pend_q && (!out_valid_q || rsp_o.ready);
  assign full        = (cnt_q == CntW'(DEPTH));
  assign empty       = (cnt_q == '0);

  // neighbor wiring; the head cell sees the incoming word as its left neighbor
  for (genvar i = 0; i < DEPTH; i++) begin : g_row
    if (i == 0) begin : g_head
      assign left_in[i] = '{valid: 1'b1, word: req_i.value};
    end else begin : g_mid
      assign left_in[i] = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_in[i] = '{valid: 1'b0, word: '0};
    end else begin : g_inner
      assign right_in[i] = cell_q[i+1];
    end

    dq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .push_word_i (req_i.value),
      .left_i      (left_in[i]),
      .right_i     (right_in[i]),
      .cell_o      (cell_q[i])
    );
  end

  // word of the last occupied cell
  always_comb begin
    tail_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_q[i].valid && !right_in[i].valid) begin
        tail_word = tail_word | cell_q[i].word;
      end
    end
  end

  // request decode
  always_comb begin
    ctrl  = '0;
    cnt_d = cnt_q;
    st_d  = ST_OK;
    pop_d = '0;
    if (accept) begin
      unique case (req_e'(req_i.req_type))
        REQ_PUSH_FRONT: begin
          if (full) begin
            st_d = ST_FULL;
          end else begin
            ctrl.shift_in_front = 1'b1;
            cnt_d = cnt_q + 1'b1;
          end
        end
        REQ_PUSH_BACK: begin
          if (full) begin
            st_d = ST_FULL;
          end else begin
            ctrl.push_back = 1'b1;
            cnt_d = cnt_q + 1'b1;
          end
        end
        REQ_POP_FRONT: begin
          if (empty) begin
            st_d = ST_EMPTY;
          end else begin
            ctrl.shift_out_front = 1'b1;
            pop_d = cell_q[0].word;
            cnt_d = cnt_q - 1'b1;
          end
        end
        REQ_POP_BACK: begin
          if (empty) begin
            st_d = ST_EMPTY;
          end else begin
            ctrl.pop_back = 1'b1;
            pop_d = tail_word;
            cnt_d = cnt_q - 1'b1;
          end
        end
        REQ_CLEAR: begin
          ctrl.clear = 1'b1;
          cnt_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // count and pending result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      pend_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pop_q <= pop_d;
      st_q  <= st_d;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pend_q) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign cnt_ext = {{CountW{1'b0}}, cnt_q};

  // result payload, taken from the updated row
  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      out_pop_q   <= pop_q;
      out_st_q    <= st_q;
      out_cnt_q   <= cnt_ext[CountW-1:0];
      out_front_q <= empty ? '0 : cell_q[0].word;
      out_back_q  <= empty ? '0 : tail_word;
      out_empty_q <= empty;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.popped     = out_pop_q;
  assign rsp_o.status     = out_st_q;
  assign rsp_o.count      = out_cnt_q;
  assign rsp_o.front_word = out_front_q;
  assign rsp_o.back_word  = out_back_q;
  assign rsp_o.is_empty   = out_empty_q;

endmodule

/* bench/double_ended_queue_top_test.sv */
`timescale 1ns / 1ps
// self-checking bench for the double-ended queue top level
module double_ended_queue_top_test;
  import dq_pkg::*;

  localparam int unsigned QDepth      = 16;
  localparam int unsigned LastCode    = (1 << ReqW) - 1;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned RandomItems = 550;
  localparam int unsigned MaxReports  = 10;

  // one predicted response transaction
  typedef struct packed {
    logic signed [WordW-1:0]  popped;
    status_e                  status;
    logic        [CountW-1:0] count;
    logic signed [WordW-1:0]  front_word;
    logic signed [WordW-1:0]  back_word;
    logic                     is_empty;
  } dq_result_t;

  logic clk;
  logic rst_n;

  dq_req_if req_ch ();
  dq_rsp_if rsp_ch ();

  double_ended_queue_top #(.DEPTH(QDepth)) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_ch),
    .rsp_o (rsp_ch)
  );

  // shadow contents, front of the queue at index 0
  logic signed [WordW-1:0] deque_words[$];
  dq_result_t              pending_results[$];

  bit steady_mode;
  int error_count;
  int mismatch_count;
  int checked_count;
  int request_count;
  int empty_pops;
  int full_drops;
  int peak_count;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // apply one request to the shadow deque and return the response it should give
  function automatic dq_result_t predict_deque(logic [ReqW-1:0] kind,
                                               logic signed [WordW-1:0] word);
    dq_result_t res;
    res = '0;
    case (kind)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (deque_words.size() >= QDepth) begin
          res.status = ST_FULL;
          full_drops++;
        end else if (kind == REQ_PUSH_FRONT) begin
          deque_words.push_front(word);
        end else begin
          deque_words.push_back(word);
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (deque_words.size() == 0) begin
          res.status = ST_EMPTY;
          empty_pops++;
        end else if (kind == REQ_POP_FRONT) begin
          res.popped = deque_words.pop_front();
        end else begin
          res.popped = deque_words.pop_back();
        end
      end
      REQ_CLEAR: begin
        deque_words.delete();
      end
      default: ;
    endcase
    res.count    = CountW'(deque_words.size());
    res.is_empty = (deque_words.size() == 0);
    if (deque_words.size() != 0) begin
      res.front_word = deque_words[0];
      res.back_word  = deque_words[deque_words.size() - 1];
    end
    if (deque_words.size() > peak_count) peak_count = deque_words.size();
    return res;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (steady_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // push payload with a bias toward the extremes
  function automatic logic signed [WordW-1:0] rand_word();
    case ($urandom_range(0, 15))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return '0;
      3:       return '1;
      4:       return 32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // drive one request transaction and hold it until accepted
  task automatic send_request(input logic [ReqW-1:0] kind,
                              input logic signed [WordW-1:0] word);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.value    <= word;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // hold off the sender until every response has come back
  task automatic wait_all_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // pops and unused codes on an empty queue, then clear
  task automatic test_empty_queue();
    send_request(REQ_POP_FRONT, rand_word());
    send_request(REQ_POP_BACK, rand_word());
    for (int code = REQ_CLEAR + 1; code <= LastCode; code++) begin
      send_request(ReqW'(code), rand_word());
    end
    send_request(REQ_CLEAR, rand_word());
  endtask

  // extreme words through both ends, then push into an emptied queue
  task automatic test_word_extremes();
    send_request(REQ_PUSH_BACK, 32'sh7fffffff);
    send_request(REQ_PUSH_FRONT, 32'sh80000000);
    send_request(REQ_PUSH_BACK, '1);
    send_request(REQ_PUSH_FRONT, '0);
    send_request(REQ_POP_FRONT, '1);
    send_request(REQ_POP_BACK, '0);
    send_request(REQ_POP_BACK, 32'sh55555555);
    send_request(REQ_POP_FRONT, 32'shaaaaaaaa);
    send_request(REQ_PUSH_FRONT, 32'sd1);
    send_request(REQ_POP_BACK, rand_word());
    wait_all_results();
  endtask

  // random sequences: fill to overflow, drain to underflow, mixed traffic, noise
  task automatic test_random_traffic();
    int sent;
    int pick;
    int r;
    logic [ReqW-1:0] kind;
    sent = 0;
    pick = 0;
    while (sent < RandomItems) begin
      steady_mode = ($urandom_range(0, 3) == 0);
      if (sent != 0) pick = $urandom_range(0, 99);
      if (pick < 25) begin
        // fill past full from either end
        for (int i = 0; i < QDepth + 2; i++) begin
          kind = $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
          send_request(kind, rand_word());
        end
        sent += QDepth + 2;
      end else if (pick < 50) begin
        // drain past empty from either end
        for (int i = 0; i < QDepth + 2; i++) begin
          kind = $urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK;
          send_request(kind, rand_word());
        end
        sent += QDepth + 2;
      end else if (pick < 90) begin
        // mixed traffic at both ends of the row
        for (int i = 0; i < 24; i++) begin
          r = $urandom_range(0, 99);
          if (r < 23)      kind = REQ_PUSH_FRONT;
          else if (r < 46) kind = REQ_PUSH_BACK;
          else if (r < 70) kind = REQ_POP_FRONT;
          else if (r < 94) kind = REQ_POP_BACK;
          else if (r < 97) kind = REQ_CLEAR;
          else             kind = ReqW'($urandom_range(REQ_CLEAR + 1, LastCode));
          send_request(kind, rand_word());
          if (kind <= REQ_CLEAR) sent++;
        end
      end else begin
        // unused codes and clears
        for (int i = 0; i < 3; i++) begin
          kind = $urandom_range(0, 1) ? REQ_CLEAR :
                                        ReqW'($urandom_range(REQ_CLEAR + 1, LastCode));
          send_request(kind, rand_word());
          if (kind == REQ_CLEAR) sent++;
        end
      end
      if ($urandom_range(0, 7) == 0) wait_all_results();
    end
    steady_mode = 1'b0;
  endtask

  // response side back-pressure
  initial begin : response_stall
    int hold;
    rsp_ch.ready <= 1'b0;
    hold = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold == 0) begin
        if (rsp_ch.ready) begin
          hold = pick_gap();
          if (hold > 0) rsp_ch.ready <= 1'b0;
          else hold = $urandom_range(1, 12);
        end else begin
          rsp_ch.ready <= 1'b1;
          hold = $urandom_range(1, 12);
        end
      end else begin
        hold--;
      end
      @(posedge clk);
    end
  end

  // predict on each request transaction, compare each response transaction
  always @(posedge clk) begin : scoreboard
    dq_result_t oldest;
    if (rst_n) begin
      if (req_ch.valid && req_ch.ready) begin
        pending_results.push_back(predict_deque(req_ch.req_type, req_ch.value));
        request_count++;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_results.size() == 0) begin
          error_count++;
          if (mismatch_count < MaxReports)
            $display("%0t: response with nothing pending: popped=%0d status=%0d count=%0d",
                     $realtime, rsp_ch.popped, rsp_ch.status, rsp_ch.count);
          mismatch_count++;
        end else begin
          oldest = pending_results.pop_front();
          checked_count++;
          if (rsp_ch.popped !== oldest.popped || rsp_ch.status !== oldest.status ||
              rsp_ch.count !== oldest.count || rsp_ch.front_word !== oldest.front_word ||
              rsp_ch.back_word !== oldest.back_word ||
              rsp_ch.is_empty !== oldest.is_empty) begin
            error_count++;
            if (mismatch_count < MaxReports)
              $display({"%0t: mismatch, expected popped=%0d status=%0d count=%0d ",
                        "front=%0d back=%0d empty=%0b, got popped=%0d status=%0d ",
                        "count=%0d front=%0d back=%0d empty=%0b"},
                       $realtime, oldest.popped, oldest.status, oldest.count,
                       oldest.front_word, oldest.back_word, oldest.is_empty,
                       rsp_ch.popped, rsp_ch.status, rsp_ch.count,
                       rsp_ch.front_word, rsp_ch.back_word, rsp_ch.is_empty);
            mismatch_count++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("no transaction for %0d cycles, %0d responses outstanding",
             IdleLimit, pending_results.size());
    $display("double_ended_queue_top_test: FAIL");
    $finish;
  end

  // sequence of tests
  initial begin
    rst_n           <= 1'b0;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= REQ_CLEAR;
    req_ch.value    <= '0;
    steady_mode     = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_queue();
    test_word_extremes();
    test_random_traffic();
    wait_all_results();

    $display("covered %0d requests, %0d responses checked, peak occupancy %0d of %0d",
             request_count, checked_count, peak_count, QDepth);
    $display("pops on empty %0d, pushes dropped when full %0d, mismatches %0d",
             empty_pops, full_drops, mismatch_count);
    if (pending_results.size() != 0) begin
      $display("%0d responses never arrived", pending_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("double_ended_queue_top_test: PASS");
    end else begin
      $display("double_ended_queue_top_test: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/dq_pkg.sv
rtl/dq_if.sv
rtl/dq_cell.sv
rtl/double_ended_queue_top.sv
bench/double_ended_queue_top_test.sv
